// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sbrd_pkg.sv -----
package sbrd_pkg;

  // Sector framing
  localparam int SECTOR_BYTES = 512;
  localparam int CRC_BYTES    = 2;
  localparam int SBC_W        = $clog2(SECTOR_BYTES);

  // Buffer bank sizing
  localparam int BANK_MAX     = 4096;
  localparam int BANK_W       = 13;
  localparam int BBC_W        = 12;
  localparam logic [BANK_W-1:0] BANK_SIZE_RESET = 13'd262;

  // Link bytes
  localparam logic [7:0] TOKEN_BYTE = 8'hFE;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;

  // Command codes
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Receive phases
  localparam logic [1:0] PH_TOKEN = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic [31:0] start_sector;
    logic        bank_select;
  } item_t;

  typedef struct packed {
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [BANK_W-1:0] write_address;
    logic              bank_full;
    logic              token_error;
    logic [31:0]       current_sector;
    logic              reading;
  } result_t;

endpackage

// ----- rtl/sbrd_in_stage.sv -----
module sbrd_in_stage import sbrd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  // Take a new item when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ----- rtl/sbrd_core.sv -----
module sbrd_core import sbrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BANK_W-1:0] cfg_data,
  input  logic              fire,
  input  item_t             item,
  output result_t           result
);

  logic [BANK_W-1:0] bank_size;
  logic              active_flag;
  logic              active_flag_next;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [SBC_W-1:0]  sector_byte_count;
  logic [SBC_W-1:0]  sector_byte_count_next;
  logic [BBC_W-1:0]  bank_byte_count;
  logic [BBC_W-1:0]  bank_byte_count_next;
  logic [31:0]       sector_counter;
  logic [31:0]       sector_counter_next;

  logic [SBC_W:0]    sbc_inc;
  logic [BANK_W-1:0] bbc_inc;
  logic [BANK_W-1:0] bank_base;

  // Hold bank size clamped to 1..BANK_MAX
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_size <= BANK_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        bank_size <= BANK_W'(1);
      end else if (cfg_data > BANK_W'(BANK_MAX)) begin
        bank_size <= BANK_W'(BANK_MAX);
      end else begin
        bank_size <= cfg_data;
      end
    end
  end

  assign sbc_inc   = {1'b0, sector_byte_count} + (SBC_W+1)'(1);
  assign bbc_inc   = {1'b0, bank_byte_count} + BANK_W'(1);
  assign bank_base = item.bank_select ? bank_size : '0;

  // Decode one item against the phase machine
  always_comb begin
    active_flag_next       = active_flag;
    phase_next             = phase;
    sector_byte_count_next = sector_byte_count;
    bank_byte_count_next   = bank_byte_count;
    sector_counter_next    = sector_counter;
    result                 = '0;

    case (item.command)
      CMD_START: begin
        sector_counter_next    = item.start_sector;
        active_flag_next       = 1'b1;
        phase_next             = PH_TOKEN;
        sector_byte_count_next = '0;
        bank_byte_count_next   = '0;
      end
      CMD_STOP: begin
        active_flag_next = 1'b0;
      end
      CMD_BYTE: begin
        if (active_flag) begin
          case (phase)
            PH_TOKEN: begin
              if (item.rx_byte == TOKEN_BYTE) begin
                phase_next             = PH_DATA;
                sector_byte_count_next = '0;
              end else if (item.rx_byte != IDLE_BYTE) begin
                result.token_error = 1'b1;
              end
            end
            PH_DATA: begin
              result.data_valid    = 1'b1;
              result.data_byte     = item.rx_byte;
              result.write_address = bank_base + {1'b0, bank_byte_count};
              // Wrap the bank position at the bank size
              if (bbc_inc >= bank_size) begin
                result.bank_full     = 1'b1;
                bank_byte_count_next = '0;
              end else begin
                bank_byte_count_next = bbc_inc[BBC_W-1:0];
              end
              // Move to the check bytes after the last payload byte
              if (sbc_inc >= (SBC_W+1)'(SECTOR_BYTES)) begin
                sector_byte_count_next = '0;
                if (CRC_BYTES == 0) begin
                  sector_counter_next = sector_counter + 32'd1;
                  phase_next          = PH_TOKEN;
                end else begin
                  phase_next = PH_CHECK;
                end
              end else begin
                sector_byte_count_next = sbc_inc[SBC_W-1:0];
              end
            end
            default: begin
              // Drop check bytes, then close the sector
              if (sbc_inc >= (SBC_W+1)'(CRC_BYTES)) begin
                sector_counter_next    = sector_counter + 32'd1;
                sector_byte_count_next = '0;
                phase_next             = PH_TOKEN;
              end else begin
                sector_byte_count_next = sbc_inc[SBC_W-1:0];
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    result.current_sector = sector_counter_next;
    result.reading        = active_flag_next;
  end

  // Advance the state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag       <= 1'b0;
      phase             <= PH_TOKEN;
      sector_byte_count <= '0;
      bank_byte_count   <= '0;
      sector_counter    <= '0;
    end else if (fire) begin
      active_flag       <= active_flag_next;
      phase             <= phase_next;
      sector_byte_count <= sector_byte_count_next;
      bank_byte_count   <= bank_byte_count_next;
      sector_counter    <= sector_counter_next;
    end
  end

endmodule

// ----- rtl/sbrd_out_stage.sv -----
module sbrd_out_stage import sbrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  // Move the held item on when the result register is free or being drained
  assign advance = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

endmodule

// ----- rtl/sd_block_read_deframer_top.sv -----
// SD multiple-block read deframer, SPI side.
// Input channel (in_valid/in_ready) carries one item per link byte or command:
// command 0 passes rx_byte, 1 starts a read at start_sector, 2 stops it.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// the payload byte with its buffer write address, bank-full and token-error
// flags, the current sector and the reading flag.
// cfg_we/cfg_data write the bank size (bytes per buffer bank) at any edge;
// change it only while no item is in flight.
// An accepted item waits in the input register; its result is decoded from it
// and registered in the result register. Throughput: one item per cycle while
// the output is not stalled, set by the sector and bank counter update between the two registers.
// When out_ready is low the result register holds and the input register
// still takes one more item; in_ready then drops until the output drains.
// Reset (rst, synchronous) empties both registers, disarms the read, clears
// the counters and sets the bank size to 262.
module sd_block_read_deframer_top import sbrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       start_sector,
  input  logic              bank_select,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              data_valid,
  output logic [7:0]        data_byte,
  output logic [12:0]       write_address,
  output logic              bank_full,
  output logic              token_error,
  output logic [31:0]       current_sector,
  output logic              reading
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  assign in_item.command      = command;
  assign in_item.rx_byte      = rx_byte;
  assign in_item.start_sector = start_sector;
  assign in_item.bank_select  = bank_select;

  sbrd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sbrd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (advance),
    .item     (held_item),
    .result   (result)
  );

  sbrd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign data_valid     = out_result.data_valid;
  assign data_byte      = out_result.data_byte;
  assign write_address  = out_result.write_address;
  assign bank_full      = out_result.bank_full;
  assign token_error    = out_result.token_error;
  assign current_sector = out_result.current_sector;
  assign reading        = out_result.reading;

endmodule

// ----- rtl/sbrd_checker.sv -----
`include "assert_macros.svh"

module sbrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        data_valid,
  input logic [7:0]  data_byte,
  input logic [12:0] write_address,
  input logic        bank_full,
  input logic        token_error,
  input logic        reading
);

  // A stalled result holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(write_address), "stalled result changed")

  // Non-payload results carry zero data and address
  `ASSERT_IMPLY(a_idle_zero, clk, rst, out_valid && !data_valid, data_byte == 8'd0 && write_address == 13'd0, "non-payload result has data")

  // Bank full only marks a payload byte
  `ASSERT_IMPLY(a_full_payload, clk, rst, out_valid && bank_full, data_valid, "bank full without payload")

  // Token error and payload are exclusive
  `ASSERT_IMPLY(a_err_excl, clk, rst, out_valid && token_error, !data_valid && !bank_full, "token error with payload")

  // Payload and errors only while a read is active
  `ASSERT_IMPLY(a_active, clk, rst, out_valid && (data_valid || token_error), reading, "output while not reading")

endmodule

bind sd_block_read_deframer_top sbrd_checker u_sbrd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .data_valid    (data_valid),
  .data_byte     (data_byte),
  .write_address (write_address),
  .bank_full     (bank_full),
  .token_error   (token_error),
  .reading       (reading)
);

// ----- tb/sv/sd_block_read_deframer_top_tb.sv -----
`timescale 1ns / 100ps

module sd_block_read_deframer_top_tb;
  import sbrd_pkg::*;

  // Command code with no meaning to the deframer
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 400;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [12:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        command = CMD_BYTE;
  logic [7:0]        rx_byte = '0;
  logic [31:0]       start_sector = '0;
  logic              bank_select = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              data_valid;
  logic [7:0]        data_byte;
  logic [12:0]       write_address;
  logic              bank_full;
  logic              token_error;
  logic [31:0]       current_sector;
  logic              reading;

  // Shadow of the deframer: bank size register and receive state
  logic [BANK_W-1:0] m_bank_size = BANK_SIZE_RESET;
  logic              m_active = 1'b0;
  logic [1:0]        m_phase = PH_TOKEN;
  int unsigned       m_sec_cnt = 0;
  int unsigned       m_bank_cnt = 0;
  logic [31:0]       m_sector = '0;

  result_t           rx_result_q[$];

  int unsigned       n_items = 0;
  int unsigned       n_effective = 0;
  int unsigned       n_results = 0;
  int unsigned       n_sectors = 0;
  int unsigned       n_token_err = 0;
  int unsigned       n_full = 0;
  int unsigned       n_cfg = 0;
  int unsigned       n_fail = 0;
  int unsigned       quiet_cycles = 0;

  // Stimulus pacing shared by sender and receiver
  logic              idle_on = 1'b0;
  int unsigned       hold_asked = 0;
  int unsigned       hold_served = 0;
  int unsigned       hold_left = 0;
  int unsigned       rdy_gap = 0;

  sd_block_read_deframer_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .rx_byte        (rx_byte),
    .start_sector   (start_sector),
    .bank_select    (bank_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_valid     (data_valid),
    .data_byte      (data_byte),
    .write_address  (write_address),
    .bank_full      (bank_full),
    .token_error    (token_error),
    .current_sector (current_sector),
    .reading        (reading)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Advance the deframer shadow by one item and return the result it causes
  function automatic result_t predict_deframe(input item_t it);
    result_t     r;
    int unsigned size;
    int unsigned addr;
    logic        close_now;
    r = '0;
    close_now = 1'b0;
    case (it.command)
      CMD_START: begin
        m_sector   = it.start_sector;
        m_active   = 1'b1;
        m_phase    = PH_TOKEN;
        m_sec_cnt  = 0;
        m_bank_cnt = 0;
      end
      CMD_STOP: m_active = 1'b0;
      CMD_BYTE: if (m_active) begin
        if (m_phase == PH_TOKEN) begin
          // Skip idle fill, open on the token, flag anything else
          if (it.rx_byte == TOKEN_BYTE) begin
            m_phase   = PH_DATA;
            m_sec_cnt = 0;
          end else if (it.rx_byte != IDLE_BYTE) begin
            r.token_error = 1'b1;
          end
        end else if (m_phase == PH_DATA) begin
          if (m_bank_size == 0) size = 1;
          else if (m_bank_size > BANK_MAX) size = BANK_MAX;
          else size = m_bank_size;
          r.data_valid = 1'b1;
          r.data_byte  = it.rx_byte;
          addr = it.bank_select * size + m_bank_cnt;
          r.write_address = addr[BANK_W-1:0];
          m_bank_cnt++;
          if (m_bank_cnt >= size) begin
            r.bank_full = 1'b1;
            m_bank_cnt  = 0;
          end
          m_sec_cnt++;
          if (m_sec_cnt >= SECTOR_BYTES) begin
            m_sec_cnt = 0;
            m_phase   = PH_CHECK;
            close_now = (CRC_BYTES == 0);
          end
        end else begin
          // Drop the check bytes
          m_sec_cnt++;
          close_now = (m_sec_cnt >= CRC_BYTES);
        end
      end
      default: ;
    endcase
    if (close_now) begin
      m_sector  = m_sector + 32'd1;
      m_sec_cnt = 0;
      m_phase   = PH_TOKEN;
      n_sectors++;
    end
    r.current_sector = m_sector;
    r.reading        = m_active;
    return r;
  endfunction

  // Sample both channels mid-cycle: predict accepted items, check results
  always @(negedge clk) begin
    item_t   it;
    result_t got;
    result_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {data_valid, data_byte, write_address, bank_full, token_error,
               current_sector, reading};
        n_results++;
        if (rx_result_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] result with no item waiting: byte %02h addr %0d sector %08h",
                     $realtime, got.data_byte, got.write_address, got.current_sector);
        end else begin
          want = rx_result_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] result mismatch (expected / actual):", $realtime);
              $display("  data_valid %0d / %0d  data_byte %02h / %02h  write_address %0d / %0d",
                       want.data_valid, got.data_valid, want.data_byte, got.data_byte,
                       want.write_address, got.write_address);
              $display("  bank_full %0d / %0d  token_error %0d / %0d  reading %0d / %0d",
                       want.bank_full, got.bank_full, want.token_error, got.token_error,
                       want.reading, got.reading);
              $display("  current_sector %08h / %08h", want.current_sector,
                       got.current_sector);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        it = {command, rx_byte, start_sector, bank_select};
        n_items++;
        if (it.command == CMD_START || it.command == CMD_STOP ||
            (it.command == CMD_BYTE && m_active))
          n_effective++;
        want = predict_deframe(it);
        if (want.token_error) n_token_err++;
        if (want.bank_full) n_full++;
        rx_result_q.push_back(want);
      end
      if (cfg_we) m_bank_size = cfg_data;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rdy_gap != 0) begin
      rdy_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rdy_gap = pick_gap();
    end
  end

  // End the run when nothing has moved for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("sd_block_read_deframer_top regression: fail");
    $finish;
  end

  // Offer one item and hold it until accepted
  task automatic send(input logic [1:0] cmd, input logic [7:0] rx,
                      input logic [31:0] sector, input logic bank);
    int unsigned gap;
    logic        taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    rx_byte      <= rx;
    start_sector <= sector;
    bank_select  <= bank;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic bank);
    send(CMD_BYTE, rx, 32'($urandom), bank);
  endtask

  // Drop valid and wait until every expected result is in
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rx_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_bank_size(input logic [BANK_W-1:0] value);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // Bytes before any start, the reserved code and a stop while disarmed
  task automatic test_ignored_items();
    send(CMD_BYTE, TOKEN_BYTE, 32'hFFFF_FFFF, 1'b1);
    send(CMD_BYTE, 8'h00, 32'h0, 1'b0);
    send(CMD_RESERVED, 8'h5A, 32'hFFFF_FFFF, 1'b1);
    send(CMD_STOP, IDLE_BYTE, 32'h0, 1'b0);
  endtask

  // Idle fill, bad tokens, then payload extremes in both banks
  task automatic test_token_and_payload();
    send(CMD_START, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_byte(IDLE_BYTE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send(CMD_RESERVED, TOKEN_BYTE, 32'h0, 1'b0);
    send_byte(TOKEN_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(TOKEN_BYTE, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // Stop holds the counters, the next start clears them
  task automatic test_stop_and_restart();
    send(CMD_STOP, 8'h00, 32'hFFFF_FFFF, 1'b1);
    send_byte(8'h33, 1'b1);
    send(CMD_START, 8'hFF, 32'h0, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(TOKEN_BYTE, 1'b1);
    send_byte(8'h01, 1'b1);
  endtask

  // Bank sizes at and past the limits, and a size lowered mid-bank
  task automatic test_bank_size_limits();
    logic [BANK_W-1:0] limit_sizes [4];
    limit_sizes = '{13'd1, 13'd0, 13'd8191, 13'd4096};
    foreach (limit_sizes[k]) begin
      set_bank_size(limit_sizes[k]);
      send(CMD_START, 8'h00, 32'h8000_0000 + 32'(k), 1'b0);
      send_byte(TOKEN_BYTE, 1'b0);
      send_byte(rand_byte(), 1'b1);
      send_byte(rand_byte(), 1'b0);
    end
    set_bank_size(13'd600);
    send(CMD_START, 8'h00, 32'h0000_1000, 1'b0);
    send_byte(TOKEN_BYTE, 1'b0);
    repeat (5) send_byte(rand_byte(), 1'b0);
    set_bank_size(13'd2);
    repeat (3) send_byte(rand_byte(), 1'b1);
    set_bank_size(BANK_SIZE_RESET);
  endtask

  // Stall the receiver while items keep coming, then drain fully
  task automatic test_backpressure();
    idle_on = 1'b0;
    send(CMD_START, 8'h00, 32'h0000_00FF, 1'b0);
    send_byte(TOKEN_BYTE, 1'b0);
    hold_asked++;
    repeat (24) send_byte(rand_byte(), rand_bit());
    wait_drained();
    repeat (8) send_byte(rand_byte(), rand_bit());
    idle_on = 1'b1;
    wait_drained();
  endtask

  function automatic logic [BANK_W-1:0] pick_bank_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 13'd1;
    if (r == 2) return 13'(BANK_MAX);
    if (r == 3) return 13'($urandom_range(BANK_MAX + 1, 8191));
    return 13'($urandom_range(2, 700));
  endfunction

  // One read: start, then a whole sector with random fill, sometimes cut short
  task automatic sector_session();
    logic [31:0] first;
    int unsigned cut_at;
    if ($urandom_range(0, 3) == 0) first = 32'hFFFF_FFFF - 32'($urandom_range(0, 1));
    else first = 32'($urandom);
    send(CMD_START, rand_byte(), first, rand_bit());
    cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SECTOR_BYTES + CRC_BYTES - 1) : 0;
    repeat ($urandom_range(0, 3)) send_byte(IDLE_BYTE, rand_bit());
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 253)), rand_bit());
    send_byte(TOKEN_BYTE, rand_bit());
    for (int i = 0; i < SECTOR_BYTES + CRC_BYTES; i++) begin
      if (cut_at != 0 && i == cut_at) begin
        // Break the sector with a stop or a fresh start
        if (rand_bit()) begin
          send(CMD_STOP, rand_byte(), 32'($urandom), rand_bit());
          repeat (2) send_byte(rand_byte(), rand_bit());
        end else begin
          send(CMD_START, rand_byte(), 32'($urandom), rand_bit());
        end
        return;
      end
      send_byte(rand_byte(), rand_bit());
    end
  endtask

  // Random reads and noise until the item budget is spent and a sector has closed
  task automatic test_random_sessions();
    while (n_items < RANDOM_ITEMS || n_sectors == 0) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0) set_bank_size(pick_bank_size());
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(5, 20))
          send(2'($urandom_range(0, 3)), rand_byte(), 32'($urandom), rand_bit());
      else
        sector_session();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;
    test_ignored_items();
    test_token_and_payload();
    test_stop_and_restart();
    test_bank_size_limits();
    test_backpressure();
    test_random_sessions();
    wait_drained();
    repeat (5) @(posedge clk);
    $display("Ran %0d items (%0d acted on), %0d results checked, %0d sectors closed,",
             n_items, n_effective, n_results, n_sectors);
    $display("%0d token errors, %0d full banks, %0d bank size writes, %0d failures",
             n_token_err, n_full, n_cfg, n_fail);
    if (n_fail == 0 && rx_result_q.size() == 0) begin
      $display("sd_block_read_deframer_top regression: pass");
    end else begin
      $display("sd_block_read_deframer_top regression: fail");
    end
    $finish;
  end

endmodule
